// File: rtl/sct_pkg.sv
// Shared types, codes and character classes for the script tokenizer.
`timescale 1ns / 1ps

package sct_pkg;

  // Width of the internal position, line and column counters (8..32).
  localparam int POS_W     = 20;
  // Width of the position fields on the result channel.
  localparam int OUT_POS_W = 20;
  // Most tokens one source byte can cause.
  localparam int MAX_RES   = 3;
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int IDX_W     = $clog2(MAX_RES);

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_DEC   = 3'd2;
  localparam logic [2:0] MODE_ZERO  = 3'd3;
  localparam logic [2:0] MODE_HEX   = 3'd4;
  localparam logic [2:0] MODE_FLOAT = 3'd5;

  // Token kinds.
  localparam logic [4:0] KIND_EOL    = 5'd0;
  localparam logic [4:0] KIND_EOF    = 5'd1;
  localparam logic [4:0] KIND_PLUS   = 5'd2;
  localparam logic [4:0] KIND_MINUS  = 5'd3;
  localparam logic [4:0] KIND_STAR   = 5'd4;
  localparam logic [4:0] KIND_SLASH  = 5'd5;
  localparam logic [4:0] KIND_SEMI   = 5'd6;
  localparam logic [4:0] KIND_COLON  = 5'd7;
  localparam logic [4:0] KIND_COMMA  = 5'd8;
  localparam logic [4:0] KIND_DOT    = 5'd9;
  localparam logic [4:0] KIND_DOLLAR = 5'd10;
  localparam logic [4:0] KIND_PCT    = 5'd11;
  localparam logic [4:0] KIND_LPAREN = 5'd12;
  localparam logic [4:0] KIND_RPAREN = 5'd13;
  localparam logic [4:0] KIND_LBRACK = 5'd14;
  localparam logic [4:0] KIND_RBRACK = 5'd15;
  localparam logic [4:0] KIND_LBRACE = 5'd16;
  localparam logic [4:0] KIND_RBRACE = 5'd17;
  localparam logic [4:0] KIND_IDENT  = 5'd18;
  localparam logic [4:0] KIND_INT    = 5'd19;
  localparam logic [4:0] KIND_FLOAT  = 5'd20;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [OUT_POS_W-1:0] opos_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] accum;
    pos_t        tstart;
    pos_t        bpos;
    pos_t        line;
    pos_t        col;
    pos_t        tline;
    pos_t        tcol;
    logic        hex_done;
  } scan_state_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [31:0] value;
    opos_t              start;
    opos_t              len;
    opos_t              line;
    opos_t              col;
  } tok_t;

  typedef tok_t [MAX_RES-1:0] tok_vec_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } hex_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.hit   = 1'b1;
    h.digit = c[3:0];
    if (c inside {["a":"f"], ["A":"F"]}) begin
      h.digit = c[3:0] + 4'd9;
    end else if (!is_digit(c)) begin
      h.hit = 1'b0;
    end
    return h;
  endfunction

  function automatic punct_t punct_kind(input logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    case (c)
      "+":     p.kind = KIND_PLUS;
      "-":     p.kind = KIND_MINUS;
      "*":     p.kind = KIND_STAR;
      "/":     p.kind = KIND_SLASH;
      ";":     p.kind = KIND_SEMI;
      ":":     p.kind = KIND_COLON;
      ",":     p.kind = KIND_COMMA;
      ".":     p.kind = KIND_DOT;
      "$":     p.kind = KIND_DOLLAR;
      "%":     p.kind = KIND_PCT;
      "(":     p.kind = KIND_LPAREN;
      ")":     p.kind = KIND_RPAREN;
      "[":     p.kind = KIND_LBRACK;
      "]":     p.kind = KIND_RBRACK;
      "{":     p.kind = KIND_LBRACE;
      "}":     p.kind = KIND_RBRACE;
      default: begin
        p.hit  = 1'b0;
        p.kind = KIND_EOL;
      end
    endcase
    return p;
  endfunction

endpackage

// File: rtl/sct_if.sv
// Stream interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface sct_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, output char_byte, output end_of_source, input ready);
  modport sink   (input valid, input char_byte, input end_of_source, output ready);
endinterface

interface sct_out_if import sct_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [4:0]           token_kind;
  logic signed [31:0]   int_value;
  logic [OUT_POS_W-1:0] start_offset;
  logic [OUT_POS_W-1:0] token_length;
  logic [OUT_POS_W-1:0] line_number;
  logic [OUT_POS_W-1:0] column_number;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output int_value, output start_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value, input start_offset,
                  input token_length, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

// File: rtl/sct_scan.sv
// One scanner step: next state and the tokens caused by one source byte.
`timescale 1ns / 1ps

module sct_scan import sct_pkg::*; (
  input  scan_state_t      st_i,
  input  logic [7:0]       char_byte,
  input  logic             end_of_source,
  output scan_state_t      st_o,
  output logic [CNT_W-1:0] tok_cnt,
  output tok_vec_t         toks
);

  function automatic scan_state_t advance(input scan_state_t s);
    scan_state_t r;
    r      = s;
    r.bpos = s.bpos + pos_t'(1);
    r.col  = s.col + pos_t'(1);
    return r;
  endfunction

  function automatic logic open_mode(input logic [2:0] m);
    return m inside {MODE_IDENT, MODE_DEC, MODE_ZERO, MODE_HEX, MODE_FLOAT};
  endfunction

  function automatic tok_t flush_tok(input scan_state_t s);
    tok_t t;
    t.kind  = KIND_INT;
    t.value = s.accum;
    if (s.mode == MODE_IDENT) begin
      t.kind  = KIND_IDENT;
      t.value = '0;
    end else if (s.mode == MODE_FLOAT) begin
      t.kind  = KIND_FLOAT;
      t.value = '0;
    end
    t.start = opos_t'(s.tstart);
    t.len   = opos_t'(pos_t'(s.bpos - s.tstart));
    t.line  = opos_t'(s.tline);
    t.col   = opos_t'(s.tcol);
    return t;
  endfunction

  function automatic tok_t here_tok(input scan_state_t s, input logic [4:0] kind,
                                    input logic [OUT_POS_W-1:0] len);
    tok_t t;
    t.kind  = kind;
    t.value = '0;
    t.start = opos_t'(s.bpos);
    t.len   = len;
    t.line  = opos_t'(s.line);
    t.col   = opos_t'(s.col);
    return t;
  endfunction

  scan_state_t      s;
  logic [CNT_W-1:0] n;
  logic             taken;
  hex_t             hx;
  punct_t           pk;
  logic [31:0]      dig;

  always_comb begin
    s     = st_i;
    n     = '0;
    toks  = '0;
    taken = 1'b0;
    hx    = hex_val(char_byte);
    pk    = punct_kind(char_byte);
    dig   = {28'd0, char_byte[3:0]};

    if (char_byte != CH_NUL) begin
      // continue the open token if this byte belongs to it
      case (s.mode)
        MODE_IDENT: taken = is_digit(char_byte) || is_alpha(char_byte);
        MODE_DEC: begin
          if (is_digit(char_byte)) begin
            s.accum = (s.accum << 3) + (s.accum << 1) + dig;
            taken   = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (is_digit(char_byte)) begin
            s.mode  = MODE_DEC;
            s.accum = dig;
            taken   = 1'b1;
          end else if (char_byte == CH_LOWER_X) begin
            s.mode = MODE_HEX;
            taken  = 1'b1;
          end else if (char_byte == CH_LOWER_F) begin
            s.mode = MODE_FLOAT;
            taken  = 1'b1;
          end
        end
        MODE_HEX: begin
          if (hx.hit) begin
            if (!s.hex_done) begin
              s.accum = {s.accum[27:0], hx.digit};
            end
            taken = 1'b1;
          end else if (char_byte == CH_LOWER_X) begin
            s.hex_done = 1'b1;
            taken      = 1'b1;
          end
        end
        MODE_FLOAT: taken = is_digit(char_byte) || (char_byte == CH_DOT);
        default:    taken = 1'b0;
      endcase

      if (taken) begin
        s = advance(s);
      end else begin
        if (open_mode(s.mode)) begin
          toks[n[IDX_W-1:0]] = flush_tok(s);
          n = n + CNT_W'(1);
        end
        s.mode = MODE_IDLE;

        if (is_alpha(char_byte) || is_digit(char_byte)) begin
          s.mode     = MODE_IDENT;
          s.accum    = '0;
          if (is_digit(char_byte)) begin
            s.mode  = (char_byte == CH_ZERO) ? MODE_ZERO : MODE_DEC;
            s.accum = dig;
          end
          s.tstart   = s.bpos;
          s.tline    = s.line;
          s.tcol     = s.col;
          s.hex_done = 1'b0;
          s          = advance(s);
        end else if (char_byte == CH_NEWLINE) begin
          toks[n[IDX_W-1:0]] = here_tok(s, KIND_EOL, opos_t'(1));
          n      = n + CNT_W'(1);
          s.bpos = s.bpos + pos_t'(1);
          s.line = s.line + pos_t'(1);
          s.col  = '0;
        end else begin
          if (pk.hit) begin
            toks[n[IDX_W-1:0]] = here_tok(s, pk.kind, opos_t'(1));
            n = n + CNT_W'(1);
          end
          s = advance(s);
        end
      end
    end

    // end of source: flush, then eof, then back to reset
    if (char_byte == CH_NUL || end_of_source) begin
      if (open_mode(s.mode)) begin
        toks[n[IDX_W-1:0]] = flush_tok(s);
        n = n + CNT_W'(1);
      end
      toks[n[IDX_W-1:0]] = here_tok(s, KIND_EOF, '0);
      n = n + CNT_W'(1);
      s = '0;
    end

    st_o    = s;
    tok_cnt = n;
  end

endmodule

// File: rtl/script_char_tokenizer_core.sv
// Top level of the script tokenizer: input register, scanner step, token output register.
`timescale 1ns / 1ps

// Takes one source byte per transfer and returns tokens with their offset, length,
// line and column. A byte is registered on entry and is scanned once the output register
// has no token left or its last token is taken; the scanner state and the byte's tokens
// (up to three) are written to the output register in a single pass. The output register
// shows one token per cycle while the receiver is ready, so a byte that gives several
// tokens holds the output until all are taken; bytes that give zero or one token stream
// at one byte per cycle while the receiver is ready, and the next byte is taken while a
// token still waits. A zero byte or end_of_source flushes any open token, emits end-of-file
// and returns the scanner to its reset state.
module script_char_tokenizer_core import sct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sct_in_if.sink    in_chan,
  sct_out_if.source out_chan
);

  scan_state_t      state_r;
  scan_state_t      state_nxt;
  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic [CNT_W-1:0] bnd_cnt_r;
  logic [IDX_W-1:0] bnd_idx_r;
  tok_vec_t         bnd_tok_r;
  logic [CNT_W-1:0] scan_cnt;
  tok_vec_t         scan_toks;
  logic             out_fire;
  logic             bnd_done;
  logic             process;
  tok_t             cur_tok;

  sct_scan u_scan (
    .st_i          (state_r),
    .char_byte     (in_byte_r),
    .end_of_source (in_last_r),
    .st_o          (state_nxt),
    .tok_cnt       (scan_cnt),
    .toks          (scan_toks)
  );

  assign out_fire = out_chan.valid && out_chan.ready;
  assign bnd_done = out_fire && (CNT_W'(bnd_idx_r) == bnd_cnt_r - CNT_W'(1));
  assign process  = in_vld_r && ((bnd_cnt_r == '0) || bnd_done);

  assign in_chan.ready = !in_vld_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.char_byte;
      in_last_r <= in_chan.end_of_source;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      bnd_cnt_r <= '0;
      bnd_idx_r <= '0;
    end else if (process) begin
      state_r   <= state_nxt;
      bnd_cnt_r <= scan_cnt;
      bnd_idx_r <= '0;
    end else if (bnd_done) begin
      bnd_cnt_r <= '0;
      bnd_idx_r <= '0;
    end else if (out_fire) begin
      bnd_idx_r <= bnd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      bnd_tok_r <= scan_toks;
    end
  end

  assign cur_tok                = bnd_tok_r[bnd_idx_r];
  assign out_chan.valid         = (bnd_cnt_r != '0);
  assign out_chan.token_kind    = cur_tok.kind;
  assign out_chan.int_value     = cur_tok.value;
  assign out_chan.start_offset  = cur_tok.start;
  assign out_chan.token_length  = cur_tok.len;
  assign out_chan.line_number   = cur_tok.line;
  assign out_chan.column_number = cur_tok.col;
  assign out_chan.last_of_run   = (CNT_W'(bnd_idx_r) == bnd_cnt_r - CNT_W'(1));

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bnd_cnt_r != '0) |-> (CNT_W'(bnd_idx_r) < bnd_cnt_r))
    else $error("token index beyond bundle count");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.token_kind == KIND_EOF)) |-> out_chan.last_of_run)
    else $error("eof token is not the last of its run");

  a_end_gives_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (process && (in_last_r || (in_byte_r == CH_NUL))) |-> (scan_cnt != '0))
    else $error("end of source without eof token");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (process && (in_last_r || (in_byte_r == CH_NUL))) |=>
      ((state_r.bpos == '0) && (state_r.mode == MODE_IDLE)))
    else $error("scanner state not cleared after end of source");

endmodule
